[src/gray_box_downsampler_macros.svh]
// Assertion macros shared by the gray box downsampler RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef GRAY_BOX_DOWNSAMPLER_MACROS_SVH
`define GRAY_BOX_DOWNSAMPLER_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define GBD_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Implication checked in the same cycle outside reset.
`define GBD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[src/gbd_pkg.sv]
// Package for the gray box downsampler: field widths, register indexes,
// reset values and the result beat type. No dependencies.
package gbd_pkg;

  localparam int DEF_MAX_SOURCE_SIDE  = 4096;
  localparam int DEF_MAX_OUTPUT_WIDTH = 512;

  localparam int PIX_W      = 8;
  localparam int SUM_W      = 14;
  localparam int OUT_X_W    = 9;
  localparam int OUT_Y_W    = 12;
  localparam int SIDE_CFG_W = 13;
  localparam int FIT_W      = 9;
  localparam int SHIFT_W    = 2;
  localparam int SHIFT_MAX  = (1 << SHIFT_W) - 1;
  localparam int LAST_W     = SHIFT_MAX;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SIDE_CFG_W;

  localparam logic [SIDE_CFG_W-1:0] RST_SOURCE_SIDE = SIDE_CFG_W'(480);
  localparam logic [FIT_W-1:0]      RST_FIT_LIMIT   = FIT_W'(480);
  localparam logic [SHIFT_W-1:0]    RST_MAX_SHIFT   = SHIFT_W'(3);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_WIDTH  = 2'd0,
    CFG_SOURCE_HEIGHT = 2'd1,
    CFG_FIT_LIMIT     = 2'd2,
    CFG_MAX_SHIFT     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0]   gray;
    logic [OUT_X_W-1:0] x;
    logic [OUT_Y_W-1:0] y;
    logic               frame_end;
  } out_beat_t;

endpackage

[src/gbd_in_if.sv]
// Input pixel channel of the gray box downsampler: valid, ready, one pixel.
// Depends on gbd_pkg.
interface gbd_in_if import gbd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] gray_in;

  modport source (output valid, output gray_in, input ready);
  modport sink (input valid, input gray_in, output ready);
endinterface

[src/gbd_out_if.sv]
// Result channel of the gray box downsampler: valid, ready, averaged pixel
// with its coordinates and the frame end flag. Depends on gbd_pkg.
interface gbd_out_if import gbd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   gray_out;
  logic [OUT_X_W-1:0] out_x;
  logic [OUT_Y_W-1:0] out_y;
  logic               frame_end;

  modport source (output valid, output gray_out, output out_x, output out_y,
                  output frame_end, input ready);
  modport sink (input valid, input gray_out, input out_x, input out_y,
                input frame_end, output ready);
endinterface

[src/gbd_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module gbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/gray_box_downsampler.sv]
// Top level of the gray box downsampler: configuration registers, raster
// counters, block sum RAM with read-modify-write, and result queue.
// Depends on gbd_pkg, gbd_in_if, gbd_out_if, gbd_ram and the macro header.
//
// Usage: source pixels arrive on in_pix in raster order, one beat per pixel.
// Registers are written through cfg_we, cfg_addr and cfg_data while the block
// is idle; in_pix.ready drops for one cycle after each write while the scale
// factor and output size are recomputed. The factor is a power of two chosen
// from the source size, the fit limit and the largest allowed shift.
// Each source pixel is added into the block sum RAM entry of its output
// column. When the bottom-right pixel of a block arrives, the block average
// leaves on out_pix with its output column, output row and a flag on the
// last output pixel of the frame. Columns and rows beyond whole blocks
// produce nothing.
// Throughput: one pixel per clock while in_pix.ready is high, set by the
// single RAM read and write per pixel; a read that follows a write to the
// same column takes the new sum from a bypass register. Each result goes from
// the stage one registers into a four-beat result queue, which absorbs
// stalls; in_pix.ready falls when the queue and the pixel in flight could
// fill it. Synchronous reset clears the counters, the queue and restores the
// default configuration; the block sum RAM needs no clearing.
`include "gray_box_downsampler_macros.svh"

module gray_box_downsampler import gbd_pkg::*; #(
  parameter int MAX_SOURCE_SIDE  = DEF_MAX_SOURCE_SIDE,
  parameter int MAX_OUTPUT_WIDTH = DEF_MAX_OUTPUT_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  gbd_in_if.sink                in_pix,
  gbd_out_if.source             out_pix
);

  localparam int CW    = $clog2(MAX_SOURCE_SIDE);
  localparam int IW    = CW + 1;
  localparam int SW    = $clog2(MAX_SOURCE_SIDE + 1);
  localparam int OW    = $clog2(MAX_OUTPUT_WIDTH + 1);
  localparam int WW    = (SW > OW) ? SW : OW;
  localparam int AW    = $clog2(MAX_OUTPUT_WIDTH);
  localparam int EXT_W = (SW > SIDE_CFG_W) ? SW : SIDE_CFG_W;
  localparam int CMP_W = (EXT_W > FIT_W) ? EXT_W : FIT_W;

  // Configuration registers.
  logic [SIDE_CFG_W-1:0] src_w_r, src_h_r;
  logic [FIT_W-1:0]      fit_r;
  logic [SHIFT_W-1:0]    max_shift_r;
  logic                  cfg_hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r     <= RST_SOURCE_SIDE;
      src_h_r     <= RST_SOURCE_SIDE;
      fit_r       <= RST_FIT_LIMIT;
      max_shift_r <= RST_MAX_SHIFT;
      cfg_hold_r  <= 1'b1;
    end else begin
      cfg_hold_r <= cfg_we;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_SOURCE_WIDTH:  src_w_r     <= cfg_data[SIDE_CFG_W-1:0];
          CFG_SOURCE_HEIGHT: src_h_r     <= cfg_data[SIDE_CFG_W-1:0];
          CFG_FIT_LIMIT:     fit_r       <= cfg_data[FIT_W-1:0];
          CFG_MAX_SHIFT:     max_shift_r <= cfg_data[SHIFT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Derived geometry, computed from the configuration registers and registered.
  logic [EXT_W-1:0]   w_ext, h_ext;
  logic [SW-1:0]      w_c, h_c, out_h_c;
  logic [SHIFT_W-1:0] shift_c;
  logic [LAST_W-1:0]  last_c;
  logic [WW-1:0]      out_w_full, out_w_c;

  always_comb begin
    w_ext = EXT_W'(src_w_r);
    h_ext = EXT_W'(src_h_r);
    if (w_ext == '0) begin
      w_ext = EXT_W'(1);
    end else if (w_ext > EXT_W'(MAX_SOURCE_SIDE)) begin
      w_ext = EXT_W'(MAX_SOURCE_SIDE);
    end
    if (h_ext == '0) begin
      h_ext = EXT_W'(1);
    end else if (h_ext > EXT_W'(MAX_SOURCE_SIDE)) begin
      h_ext = EXT_W'(MAX_SOURCE_SIDE);
    end
    w_c = SW'(w_ext);
    h_c = SW'(h_ext);
    shift_c = '0;
    for (int k = 0; k < SHIFT_MAX; k++) begin
      if (shift_c == SHIFT_W'(k) && SHIFT_W'(k) < max_shift_r &&
          (CMP_W'(w_c >> k) > CMP_W'(fit_r) || CMP_W'(h_c >> k) > CMP_W'(fit_r))) begin
        shift_c = SHIFT_W'(k + 1);
      end
    end
    last_c     = LAST_W'((1 << shift_c) - 1);
    out_w_full = WW'(w_c >> shift_c);
    out_w_c    = (out_w_full > WW'(MAX_OUTPUT_WIDTH)) ? WW'(MAX_OUTPUT_WIDTH) : out_w_full;
    out_h_c    = h_c >> shift_c;
  end

  logic [SW-1:0]      w_r, h_r, out_h_r, out_h_m1_r;
  logic [WW-1:0]      out_w_r, out_w_m1_r;
  logic [SHIFT_W-1:0] shift_r;
  logic [LAST_W-1:0]  last_r;

  always_ff @(posedge clk) begin
    w_r        <= w_c;
    h_r        <= h_c;
    shift_r    <= shift_c;
    last_r     <= last_c;
    out_w_r    <= out_w_c;
    out_w_m1_r <= out_w_c - WW'(1);
    out_h_r    <= out_h_c;
    out_h_m1_r <= out_h_c - SW'(1);
  end

  // Accept stage: raster position, block position and RAM read.
  logic              accept;
  logic [CW-1:0]     col_r, row_r, col_nxt, row_nxt;
  logic [CW-1:0]     ox, oy;
  logic [LAST_W-1:0] bx, by;
  logic              in_blk, blk_first, blk_end, is_last;
  logic [IW-1:0]     col_inc, row_inc;

  logic                  s1_valid_r;
  logic [FIFO_CNT_W-1:0] fifo_cnt_r;

  assign in_pix.ready = !cfg_hold_r &&
                        (fifo_cnt_r + FIFO_CNT_W'(s1_valid_r)) < FIFO_CNT_W'(FIFO_DEPTH);
  assign accept = in_pix.valid && in_pix.ready;

  always_comb begin
    ox        = col_r >> shift_r;
    oy        = row_r >> shift_r;
    bx        = LAST_W'(col_r) & last_r;
    by        = LAST_W'(row_r) & last_r;
    in_blk    = (WW'(ox) < out_w_r) && (SW'(oy) < out_h_r);
    blk_first = (bx == '0) && (by == '0);
    blk_end   = (bx == last_r) && (by == last_r);
    is_last   = (WW'(ox) == out_w_m1_r) && (SW'(oy) == out_h_m1_r);
    col_inc   = IW'(col_r) + IW'(1);
    row_inc   = IW'(row_r) + IW'(1);
    col_nxt   = col_r;
    row_nxt   = row_r;
    if (accept) begin
      if (col_inc >= IW'(w_r)) begin
        col_nxt = '0;
        row_nxt = (row_inc >= IW'(h_r)) ? '0 : CW'(row_inc);
      end else begin
        col_nxt = CW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Stage one: add into the block sum and write it back.
  logic               s1_act_r, s1_first_r, s1_emit_r, s1_fe_r;
  logic [CW-1:0]      s1_ox_r, s1_oy_r;
  logic [AW-1:0]      s1_addr_r;
  logic [PIX_W-1:0]   s1_gray_r;
  logic               fwd_valid_r;
  logic [AW-1:0]      fwd_addr_r;
  logic [SUM_W-1:0]   fwd_data_r;
  logic [SUM_W-1:0]   ram_rdata, old_sum, sum_c;
  logic               ram_we, fifo_push, fifo_pop;
  logic [OUT_X_W+CW-1:0] x_ext;
  logic [OUT_Y_W+CW-1:0] y_ext;
  out_beat_t          push_beat;

  gbd_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_OUTPUT_WIDTH)
  ) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr_r),
    .wdata (sum_c),
    .re    (accept),
    .raddr (AW'(ox)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= accept;
      fwd_valid_r <= ram_we;
    end
    if (accept) begin
      s1_act_r   <= in_blk;
      s1_first_r <= blk_first;
      s1_emit_r  <= in_blk && blk_end;
      s1_fe_r    <= is_last;
      s1_ox_r    <= ox;
      s1_oy_r    <= oy;
      s1_addr_r  <= AW'(ox);
      s1_gray_r  <= in_pix.gray_in;
    end
    fwd_addr_r <= s1_addr_r;
    fwd_data_r <= sum_c;
  end

  always_comb begin
    if (s1_first_r) begin
      old_sum = '0;
    end else if (fwd_valid_r && fwd_addr_r == s1_addr_r) begin
      old_sum = fwd_data_r;
    end else begin
      old_sum = ram_rdata;
    end
    sum_c     = old_sum + SUM_W'(s1_gray_r);
    ram_we    = s1_valid_r && s1_act_r;
    fifo_push = s1_valid_r && s1_emit_r;
    x_ext     = (OUT_X_W+CW)'(s1_ox_r);
    y_ext     = (OUT_Y_W+CW)'(s1_oy_r);
    push_beat.gray      = PIX_W'(sum_c >> {shift_r, 1'b0});
    push_beat.x         = x_ext[OUT_X_W-1:0];
    push_beat.y         = y_ext[OUT_Y_W-1:0];
    push_beat.frame_end = s1_fe_r;
  end

  // Result queue.
  out_beat_t             fifo_mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  out_beat_t             head;

  assign head              = fifo_mem_r[rd_ptr_r];
  assign out_pix.valid     = (fifo_cnt_r != '0);
  assign out_pix.gray_out  = head.gray;
  assign out_pix.out_x     = head.x;
  assign out_pix.out_y     = head.y;
  assign out_pix.frame_end = head.frame_end;
  assign fifo_pop          = out_pix.valid && out_pix.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (fifo_push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (fifo_pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + FIFO_CNT_W'(fifo_push) - FIFO_CNT_W'(fifo_pop);
    end
    if (fifo_push) begin
      fifo_mem_r[wr_ptr_r] <= push_beat;
    end
  end

  `GBD_ASSERT_NOW(a_fifo_bound, fifo_cnt_r <= FIFO_CNT_W'(FIFO_DEPTH), "result queue overfilled")
  `GBD_ASSERT_IMP(a_push_room, s1_valid_r, fifo_cnt_r < FIFO_CNT_W'(FIFO_DEPTH), "no queue room for pixel in flight")
  `GBD_ASSERT_IMP(a_push_col, fifo_push, WW'(s1_ox_r) < out_w_r, "result column outside output width")

endmodule

[verif/gray_avg_checker.sv]
`timescale 1ns / 1ps
// Checker for the gray box downsampler: follows register writes and pixel beats,
// predicts every block average and compares it with the result beats.
// Depends on gbd_pkg, gbd_in_if and gbd_out_if.
module gray_avg_checker import gbd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  gbd_in_if                     in_ch,
  gbd_out_if                    out_ch,
  output int                    mismatches,
  output int                    backlog
);
  logic [SIDE_CFG_W-1:0] side_w;
  logic [SIDE_CFG_W-1:0] side_h;
  logic [FIT_W-1:0]      fit;
  logic [SHIFT_W-1:0]    max_shift;
  logic [SUM_W-1:0]      col_sums [DEF_MAX_OUTPUT_WIDTH];
  int unsigned           col_pos;
  int unsigned           row_pos;
  int                    errs = 0;
  out_beat_t             pending_avgs [$];
  out_beat_t             want;
  out_beat_t             got;

  function automatic int unsigned clamp_side(input logic [SIDE_CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > DEF_MAX_SOURCE_SIDE) return DEF_MAX_SOURCE_SIDE;
    return v;
  endfunction

  // Adds one source pixel into its block sum and advances the raster position.
  // Returns 1 when the pixel completes a block, with the average in avg.
  function automatic bit accumulate_pixel(input logic [PIX_W-1:0] g, output out_beat_t avg);
    int unsigned w, h, s, lastm, out_w, out_h, ox, oy, bx, by;
    logic [SUM_W-1:0] sum;
    bit hit;
    w = clamp_side(side_w);
    h = clamp_side(side_h);
    s = 0;
    while (s < max_shift && ((w >> s) > fit || (h >> s) > fit)) s++;
    lastm = (1 << s) - 1;
    out_w = w >> s;
    out_h = h >> s;
    if (out_w > DEF_MAX_OUTPUT_WIDTH) out_w = DEF_MAX_OUTPUT_WIDTH;
    ox = col_pos >> s;
    oy = row_pos >> s;
    bx = col_pos & lastm;
    by = row_pos & lastm;
    hit = 1'b0;
    avg = '0;
    if (ox < out_w && oy < out_h) begin
      sum = (bx == 0 && by == 0) ? '0 : col_sums[ox];
      sum = sum + g;
      col_sums[ox] = sum;
      if (bx == lastm && by == lastm) begin
        avg.gray = PIX_W'(sum >> (2 * s));
        avg.x = OUT_X_W'(ox);
        avg.y = OUT_Y_W'(oy);
        avg.frame_end = (ox == out_w - 1 && oy == out_h - 1);
        hit = 1'b1;
      end
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return hit;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      side_w = RST_SOURCE_SIDE;
      side_h = RST_SOURCE_SIDE;
      fit = RST_FIT_LIMIT;
      max_shift = RST_MAX_SHIFT;
      foreach (col_sums[i]) col_sums[i] = '0;
      col_pos = 0;
      row_pos = 0;
      pending_avgs.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_SOURCE_WIDTH:  side_w = cfg_data;
          CFG_SOURCE_HEIGHT: side_h = cfg_data;
          CFG_FIT_LIMIT:     fit = cfg_data[FIT_W-1:0];
          CFG_MAX_SHIFT:     max_shift = cfg_data[SHIFT_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (accumulate_pixel(in_ch.gray_in, want)) pending_avgs.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.gray_out, out_ch.out_x, out_ch.out_y, out_ch.frame_end};
        if (pending_avgs.size() == 0) begin
          errs++;
          $display("%0t: result beat gray=%0d x=%0d y=%0d end=%0b, expected none",
                   $time, got.gray, got.x, got.y, got.frame_end);
        end else begin
          want = pending_avgs.pop_front();
          if (got !== want) begin
            errs++;
            $display("%0t: expected gray=%0d x=%0d y=%0d end=%0b, %s",
                     $time, want.gray, want.x, want.y, want.frame_end,
                     $sformatf("got gray=%0d x=%0d y=%0d end=%0b",
                               got.gray, got.x, got.y, got.frame_end));
          end
        end
      end
    end
    mismatches <= errs;
    backlog <= pending_avgs.size();
  end
endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// Top of the gray box downsampler testbench: clock, reset, register writes,
// pixel frames and result back-pressure. Depends on gbd_pkg, both channel
// interfaces, the block and gray_avg_checker, which gives the failure count.
module testbench;
  import gbd_pkg::*;

  localparam int          RANDOM_PIXELS = 700;
  localparam int          SETTLE        = 8;
  localparam int unsigned CYCLE_LIMIT   = 5_000_000;
  localparam int unsigned BLOCK_ROWS    = 1 << SHIFT_MAX;
  localparam logic [3:0]  ALL_REGS      = '1;
  localparam logic [3:0]  NO_REGS       = '0;
  localparam logic [3:0]  ONLY_HEIGHT   = 4'(1) << CFG_SOURCE_HEIGHT;

  typedef enum int {PIX_RANDOM, PIX_MAX, PIX_ZERO, PIX_ALTERNATE} pix_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    backlog;

  logic [SIDE_CFG_W-1:0] cur_w = RST_SOURCE_SIDE;
  logic [SIDE_CFG_W-1:0] cur_h = RST_SOURCE_SIDE;
  int unsigned           row_at = 0;
  int unsigned           pixels_sent = 0;
  bit                    sink_calm;
  int unsigned           sink_hold = 0;
  int unsigned           stall_pick;
  int unsigned           cycles = 0;

  gbd_in_if  pix_in ();
  gbd_out_if pix_out ();

  gray_box_downsampler dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .in_pix   (pix_in),
    .out_pix  (pix_out)
  );

  gray_avg_checker avg_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .in_ch      (pix_in),
    .out_ch     (pix_out),
    .mismatches (mismatches),
    .backlog    (backlog)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PIX_W-1:0] pick_gray();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  function automatic int unsigned pick_side();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 20);
    if (r < 90) return $urandom_range(21, 64);
    if (r < 95) return 0;
    return $urandom_range(1, 8);
  endfunction

  function automatic int unsigned clamp_side(input logic [SIDE_CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > DEF_MAX_SOURCE_SIDE) return DEF_MAX_SOURCE_SIDE;
    return v;
  endfunction

  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else if (sink_calm) begin
      pix_out.ready <= 1'b1;
    end else begin
      stall_pick = idle_len();
      if (stall_pick != 0) begin
        pix_out.ready <= 1'b0;
        sink_hold <= stall_pick - 1;
      end else begin
        pix_out.ready <= 1'b1;
        sink_hold <= $urandom_range(0, 5);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic push_pixel(input logic [PIX_W-1:0] g, input bit calm);
    int unsigned gap;
    gap = calm ? 0 : idle_len();
    if (gap != 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.gray_in <= g;
    do @(posedge clk); while (!pix_in.ready);
  endtask

  // All results must be out and the pipeline empty before registers change.
  task automatic drain();
    pix_in.valid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes the selected registers, sends at least rows whole source rows, then
  // more until the raster row sits on a block boundary for every factor.
  task automatic run_phase(input int unsigned w, input int unsigned h, input int unsigned fit,
                           input int unsigned shf, input logic [3:0] mask,
                           input int unsigned rows, input pix_mode_t mode, input bit calm);
    int unsigned eff_w, eff_h, n;
    logic [PIX_W-1:0] g;
    if (mask[CFG_SOURCE_WIDTH]) begin
      write_reg(CFG_SOURCE_WIDTH, CFG_DATA_W'(w));
      cur_w = SIDE_CFG_W'(w);
    end
    if (mask[CFG_SOURCE_HEIGHT]) begin
      write_reg(CFG_SOURCE_HEIGHT, CFG_DATA_W'(h));
      cur_h = SIDE_CFG_W'(h);
    end
    if (mask[CFG_FIT_LIMIT]) write_reg(CFG_FIT_LIMIT, CFG_DATA_W'(fit));
    if (mask[CFG_MAX_SHIFT]) write_reg(CFG_MAX_SHIFT, CFG_DATA_W'(shf));
    cfg_we <= 1'b0;
    sink_calm <= calm;
    eff_w = clamp_side(cur_w);
    eff_h = clamp_side(cur_h);
    n = 0;
    while (n < rows || row_at % BLOCK_ROWS != 0) begin
      for (int unsigned c = 0; c < eff_w; c++) begin
        case (mode)
          PIX_MAX:       g = '1;
          PIX_ZERO:      g = '0;
          PIX_ALTERNATE: g = ((c + row_at) & 1) ? '1 : '0;
          default:       g = pick_gray();
        endcase
        push_pixel(g, calm);
      end
      pixels_sent += eff_w;
      row_at = (row_at + 1 >= eff_h) ? 0 : row_at + 1;
      n++;
    end
    drain();
  endtask

  initial begin
    int unsigned rand_start;
    pix_mode_t mode;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = CFG_SOURCE_WIDTH;
    cfg_data = '0;
    pix_in.valid = 1'b0;
    pix_in.gray_in = '0;
    pix_out.ready = 1'b0;
    sink_calm = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_phase(0, 1, 0, 0, ONLY_HEIGHT, 1, PIX_RANDOM, 1'b0);
    run_phase(4, 4, 1, 2, ALL_REGS, 4, PIX_MAX, 1'b0);
    run_phase(8, 8, 0, 3, ALL_REGS, 8, PIX_MAX, 1'b0);
    run_phase(8, 8, 0, 3, NO_REGS, 8, PIX_ZERO, 1'b1);
    run_phase(0, 0, 1, 0, ALL_REGS, 8, PIX_ALTERNATE, 1'b0);
    run_phase(11, 7, 3, 1, ALL_REGS, 7, PIX_RANDOM, 1'b0);
    run_phase(12, 8191, 511, 3, ALL_REGS, 8, PIX_RANDOM, 1'b1);
    run_phase(2, 4096, 511, 0, ALL_REGS, 8, PIX_RANDOM, 1'b1);
    run_phase(6, 20, 2, 1, ALL_REGS, 8, PIX_RANDOM, 1'b0);
    run_phase(9, 16, 3, 3, ALL_REGS, 8, PIX_RANDOM, 1'b0);
    run_phase(5, 24, 511, 0, ALL_REGS, 16, PIX_RANDOM, 1'b0);
    run_phase(5, 10, 511, 0, ONLY_HEIGHT, 8, PIX_RANDOM, 1'b0);

    rand_start = pixels_sent;
    while (pixels_sent - rand_start < RANDOM_PIXELS) begin
      mode = ($urandom_range(0, 9) < 8) ? PIX_RANDOM : pix_mode_t'($urandom_range(1, 3));
      run_phase(pick_side(), pick_side(),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 8),
                $urandom_range(0, 3), 4'($urandom_range(1, 15)), $urandom_range(1, 24),
                mode, $urandom_range(0, 4) == 0);
    end

    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && backlog == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+src
src/gbd_pkg.sv
src/gbd_in_if.sv
src/gbd_out_if.sv
src/gbd_ram.sv
src/gray_box_downsampler.sv
verif/gray_avg_checker.sv
verif/testbench.sv
